/* rtl/sogr_pkg.sv */
// Shared types and constants for the scaled outlined glyph rasterizer.
// Holds the font ROM, the palette, the sequencer states and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package sogr_pkg;

    localparam int GLYPH_COUNT = 40;
    localparam logic [5:0] SPACE_GLYPH = 6'd39;
    localparam logic [10:0] CURSOR_MAX = 11'd2047;
    localparam logic [15:0] BLACK_PIXEL = 16'h0001;
    localparam int FIRST_BIT = 27;
    localparam logic [2:0] LAST_ROW = 3'd4;

    localparam logic [1:0] MODE_ADVANCE = 2'd0;
    localparam logic [1:0] MODE_NEWLINE = 2'd1;
    localparam logic [1:0] MODE_OVERLAY = 2'd2;

    localparam logic [2:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
        3'd3, 3'd1, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd5, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4, 3'd1, 3'd1, 3'd3, 3'd2
    };

    localparam logic [27:0] GLYPH_BITS [GLYPH_COUNT] = '{
        28'h0F6DE000, 28'h0F800000, 28'h0C4AE000, 28'h0E59E000, 28'h088AF200,
        28'h0F39E000, 28'h0F3DE000, 28'h0E4A4000, 28'h0F7DE000, 28'h0F79E000,
        28'h0F6FA000, 28'h0D75C000, 28'h0F24E000, 28'h0D6DC000, 28'h0F34E000,
        28'h0F348000, 28'h0F25E000, 28'h0B7DA000, 28'h0E92E000, 28'h0E928000,
        28'h0B75A000, 28'h0924E000, 28'h08EEB188, 28'h09DFB900, 28'h06999600,
        28'h0F7C8000, 28'h069DB700, 28'h0F7EA000, 28'h0F39E000, 28'h0E924000,
        28'h09999600, 28'h08C62A20, 28'h08C63550, 28'h0B55A000, 28'h0B79E000,
        28'h0F124F00, 28'h00800000, 28'h05000000, 28'h00380000, 28'h00000000
    };

    localparam logic [15:0] PALETTE_PIXEL [8] = '{
        16'h07C1, 16'h07FF, 16'hFFC1, 16'hF83F,
        16'hF801, 16'hFC01, 16'hFFFF, 16'hF801
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } sogr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } sogr_cmd_t;

    typedef struct packed {
        logic final_square;
    } sogr_status_t;

endpackage

/* rtl/sogr_ctrl.sv */
// Sequencer controller for the glyph rasterizer.
// Drives the handshakes and issues load and step commands; uses sogr_pkg.
`timescale 1ns / 1ps

module sogr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sogr_pkg::sogr_cmd_t   cmd,
    input  sogr_pkg::sogr_status_t status
);
    import sogr_pkg::*;

    sogr_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // Emit a square whenever the output register is free or draining.
                if (!m_valid_reg || m_ready) begin
                    cmd.step     = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.final_square) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/sogr_datapath.sv */
// Datapath of the glyph rasterizer: cursor, glyph registers, cell counters
// and the output payload register. Uses sogr_pkg.
`timescale 1ns / 1ps

module sogr_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [9:0]             cfg_wr_data,
    input  logic [1:0]             s_mode,
    input  logic [5:0]             s_glyph_index,
    input  logic [2:0]             s_palette_index,
    input  logic [2:0]             s_scale,
    input  logic [7:0]             s_row_y,
    input  sogr_pkg::sogr_cmd_t    cmd,
    output sogr_pkg::sogr_status_t status,
    output logic signed [12:0]     m_x,
    output logic signed [9:0]      m_y,
    output logic [3:0]             m_side,
    output logic [15:0]            m_pixel,
    output logic                   m_last
);
    import sogr_pkg::*;

    logic [9:0]         line_start_reg;
    logic [10:0]        cursor_reg, cursor_next;
    logic signed [11:0] base_x_reg, base_x_next;
    logic [7:0]         row_y_reg;
    logic [2:0]         scale_reg;
    logic [2:0]         width_reg;
    logic [27:0]        bits_reg;
    logic [27:0]        bits_sh_reg;
    logic [15:0]        fg_reg;
    logic               pass_reg;
    logic [2:0]         col_reg;
    logic [2:0]         row_reg;
    logic [4:0]         x_off_reg;
    logic [4:0]         y_off_reg;

    logic [5:0]         glyph;
    logic [2:0]         scale_in;
    logic [2:0]         width_in;
    logic [10:0]        cursor_eff;
    logic [5:0]         advance;
    logic [11:0]        cursor_sum;
    logic               end_col;
    logic               end_row;
    logic signed [12:0] x_calc;
    logic signed [9:0]  y_calc;

    always_comb begin
        glyph      = (s_glyph_index >= 6'(GLYPH_COUNT)) ? SPACE_GLYPH : s_glyph_index;
        scale_in   = (s_scale == 3'd0) ? 3'd1 : s_scale;
        width_in   = GLYPH_WIDTH[glyph];
        cursor_eff = (s_mode == MODE_NEWLINE) ? {1'b0, line_start_reg} : cursor_reg;
        advance    = 6'(width_in * scale_in);
        cursor_sum = {1'b0, cursor_eff} + {6'd0, advance} + 12'd2;
        if (s_mode == MODE_OVERLAY) begin
            cursor_next = cursor_reg;
            base_x_next = $signed({1'b0, cursor_eff}) - 12'sd1;
        end else begin
            cursor_next = cursor_sum[11] ? CURSOR_MAX : cursor_sum[10:0];
            base_x_next = $signed({1'b0, cursor_eff});
        end
    end

    always_comb begin
        end_col = (col_reg == width_reg - 3'd1);
        end_row = (row_reg == LAST_ROW);
        status.final_square = pass_reg && end_col && end_row;
        x_calc = 13'(base_x_reg) + $signed({8'd0, x_off_reg})
                 - $signed({12'd0, !pass_reg});
        y_calc = $signed({2'd0, row_y_reg}) + $signed({5'd0, y_off_reg})
                 - $signed({9'd0, !pass_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_start_reg <= '0;
            cursor_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                line_start_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_x_reg  <= base_x_next;
            row_y_reg   <= s_row_y;
            scale_reg   <= scale_in;
            width_reg   <= width_in;
            bits_reg    <= GLYPH_BITS[glyph];
            bits_sh_reg <= GLYPH_BITS[glyph];
            fg_reg      <= PALETTE_PIXEL[s_palette_index];
            pass_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            x_off_reg   <= '0;
            y_off_reg   <= '0;
        end else if (cmd.step) begin
            m_x     <= x_calc;
            m_y     <= y_calc;
            m_side  <= pass_reg ? {1'b0, scale_reg} : {1'b0, scale_reg} + 4'd2;
            m_pixel <= (pass_reg && bits_sh_reg[FIRST_BIT]) ? fg_reg : BLACK_PIXEL;
            m_last  <= status.final_square;
            if (end_col) begin
                col_reg   <= '0;
                x_off_reg <= '0;
                if (end_row) begin
                    // Outline pass done: restart the cell walk for the fill pass.
                    row_reg     <= '0;
                    y_off_reg   <= '0;
                    pass_reg    <= 1'b1;
                    bits_sh_reg <= bits_reg;
                end else begin
                    row_reg     <= row_reg + 3'd1;
                    y_off_reg   <= y_off_reg + {2'd0, scale_reg};
                    bits_sh_reg <= {bits_sh_reg[26:0], 1'b0};
                end
            end else begin
                col_reg     <= col_reg + 3'd1;
                x_off_reg   <= x_off_reg + {2'd0, scale_reg};
                bits_sh_reg <= {bits_sh_reg[26:0], 1'b0};
            end
        end
    end

endmodule

/* rtl/scaled_outlined_glyph_rasterizer_core.sv */
// Top level of the scaled outlined glyph rasterizer.
// Instantiates sogr_ctrl and sogr_datapath; uses sogr_pkg.
`timescale 1ns / 1ps

// How to use this block:
// The input channel (s_valid/s_ready) carries one glyph transaction: mode,
// glyph index, palette index, scale and the line's top y. The result channel
// (m_valid/m_ready) carries square fill commands, 10 * width per glyph (at
// most 50), outline squares first, then the filled cells; m_last marks the
// final square of the glyph.
// The configuration port writes line_start_x whenever cfg_wr_en is high.
// After a glyph transaction is accepted, the datapath loads the glyph
// registers; then the cell counter walks the cells, one square per cycle
// while m_ready is high, and the sequencer takes no new glyph until the walk
// is done.
// A new glyph is accepted as soon as the last square sits in the output
// register, even if that square has not yet been taken.
// When the receiver stalls, the sequencer holds its position and the output
// register holds its payload until the transaction completes.
// Synchronous reset (aresetn low) clears the cursor to zero, line_start_x to
// zero and drops m_valid; an item in progress is discarded.

module scaled_outlined_glyph_rasterizer_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [9:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [5:0]         s_glyph_index,
    input  logic [2:0]         s_palette_index,
    input  logic [2:0]         s_scale,
    input  logic [7:0]         s_row_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [12:0] m_x,
    output logic signed [9:0]  m_y,
    output logic [3:0]         m_side,
    output logic [15:0]        m_pixel,
    output logic               m_last
);
    import sogr_pkg::*;

    // Command and status between the sequencer and the datapath.
    sogr_cmd_t    cmd;
    sogr_status_t status;

    sogr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // The datapath owns the cursor, the configuration register and the
    // output payload register.
    sogr_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_mode          (s_mode),
        .s_glyph_index   (s_glyph_index),
        .s_palette_index (s_palette_index),
        .s_scale         (s_scale),
        .s_row_y         (s_row_y),
        .cmd             (cmd),
        .status          (status),
        .m_x             (m_x),
        .m_y             (m_y),
        .m_side          (m_side),
        .m_pixel         (m_pixel),
        .m_last          (m_last)
    );

endmodule
